[rtl/core/fbpa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buffer pool allocator package
// Operation and status codes, controller states and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam logic [1:0] OP_GET = 2'd0;
    localparam logic [1:0] OP_PUT = 2'd1;
    localparam logic [1:0] OP_ZAP = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_NOT_ALLOC = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_GET_COMMIT,
        ST_PUT_SCAN,
        ST_ZAP_MOVE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic free_rd;
        logic get_commit;
        logic set_empty;
        logic used_rd;
        logic scan_step;
        logic put_hit;
        logic set_not_alloc;
        logic zap_move;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       free_empty;
        logic       used_empty;
        logic       match;
        logic       scan_last;
        logic       used_last;
    } sts_t;

endpackage
`default_nettype wire

[rtl/core/fbpa_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one operation word into the allocator.
// ----------------------------------------------------------------------------
interface fbpa_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] buffer_index;

    modport source (output valid, output op, output buffer_index, input ready);
    modport sink   (input valid, input op, input buffer_index, output ready);
endinterface
`default_nettype wire

[rtl/core/fbpa_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result word out of the allocator.
// ----------------------------------------------------------------------------
interface fbpa_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] granted_index;
    logic [8:0] free_count;
    logic [8:0] returned_count;

    modport source (output valid, output status, output granted_index,
                    output free_count, output returned_count, input ready);
    modport sink   (input valid, input status, input granted_index,
                    input free_count, input returned_count, output ready);
endinterface
`default_nettype wire

[rtl/core/fbpa_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/core/fbpa_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buffer pool allocator controller
// Sequences get, put and zap over the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (sts.op)
                    OP_GET:
                    begin
                        state_next = sts.free_empty ? ST_DONE : ST_GET_COMMIT;
                    end
                    OP_PUT:
                    begin
                        state_next = sts.used_empty ? ST_DONE : ST_PUT_SCAN;
                    end
                    OP_ZAP:
                    begin
                        state_next = sts.used_empty ? ST_DONE : ST_ZAP_MOVE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_GET_COMMIT:
            begin
                state_next = ST_DONE;
            end
            ST_PUT_SCAN:
            begin
                if (sts.match || sts.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ZAP_MOVE:
            begin
                if (sts.used_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
            end
            ST_DISPATCH:
            begin
                case (sts.op)
                    OP_GET:
                    begin
                        cmd.set_empty = sts.free_empty;
                        cmd.free_rd   = !sts.free_empty;
                    end
                    OP_PUT:
                    begin
                        cmd.set_not_alloc = sts.used_empty;
                        cmd.used_rd       = !sts.used_empty;
                    end
                    OP_ZAP:
                    begin
                        cmd.used_rd = !sts.used_empty;
                    end
                    default:
                    begin
                        cmd = '0;
                    end
                endcase
            end
            ST_GET_COMMIT:
            begin
                cmd.get_commit = 1'b1;
            end
            ST_PUT_SCAN:
            begin
                // A miss on the last entry still rotates it, which restores the order.
                cmd.put_hit       = sts.match;
                cmd.scan_step     = !sts.match;
                cmd.set_not_alloc = !sts.match && sts.scan_last;
            end
            ST_ZAP_MOVE:
            begin
                cmd.zap_move = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

[rtl/core/fbpa_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buffer pool allocator datapath
// Free and in-use index rings in RAM, their pointers and counts, and the
// result registers.
// ----------------------------------------------------------------------------
module fbpa_dp
    import fbpa_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cmd_t       cmd,
    output sts_t            sts,
    input  wire logic [1:0] in_op,
    input  wire logic [7:0] in_buffer_index,
    output logic      [1:0] out_status,
    output logic      [7:0] out_granted_index,
    output logic      [8:0] out_free_count,
    output logic      [8:0] out_returned_count
);

    localparam int PTR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int ENTRY_W = (PTR_W > 8) ? PTR_W : 8;

    localparam logic [SUM_W-1:0] CAP_SUM  = SUM_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CAPACITY - 1);

    // Control state
    logic [PTR_W-1:0] free_head_reg;
    logic [CNT_W-1:0] free_cnt_reg;
    logic [CNT_W-1:0] free_fill_reg;
    logic [PTR_W-1:0] used_head_reg;
    logic [CNT_W-1:0] used_cnt_reg;

    // Per-operation payload
    logic [1:0]       op_reg;
    logic [7:0]       want_reg;
    logic [1:0]       status_reg;
    logic [7:0]       granted_reg;
    logic [8:0]       returned_reg;
    logic [CNT_W-1:0] remain_reg;
    logic [PTR_W-1:0] free_raddr_reg;
    logic             free_hit_reg;

    logic [1:0]       out_status_reg;
    logic [7:0]       out_granted_reg;
    logic [8:0]       out_free_reg;
    logic [8:0]       out_returned_reg;

    logic [SUM_W-1:0]   free_sum;
    logic [SUM_W-1:0]   used_sum;
    logic [PTR_W-1:0]   free_tail;
    logic [PTR_W-1:0]   used_tail;
    logic [PTR_W-1:0]   free_head_inc;
    logic [PTR_W-1:0]   used_head_inc;
    logic [ENTRY_W-1:0] free_q;
    logic [ENTRY_W-1:0] used_q;
    logic [ENTRY_W-1:0] free_entry;
    logic [ENTRY_W-1:0] want_ext;

    logic               free_we;
    logic [ENTRY_W-1:0] free_wdata;
    logic               used_we;
    logic [ENTRY_W-1:0] used_wdata;
    logic [PTR_W-1:0]   used_raddr;

    always_comb
    begin
        free_sum  = SUM_W'(free_head_reg) + SUM_W'(free_cnt_reg);
        used_sum  = SUM_W'(used_head_reg) + SUM_W'(used_cnt_reg);
        free_tail = (free_sum >= CAP_SUM) ? PTR_W'(free_sum - CAP_SUM) : PTR_W'(free_sum);
        used_tail = (used_sum >= CAP_SUM) ? PTR_W'(used_sum - CAP_SUM) : PTR_W'(used_sum);
        free_head_inc = (free_head_reg == LAST_PTR) ? '0 : free_head_reg + 1'b1;
        used_head_inc = (used_head_reg == LAST_PTR) ? '0 : used_head_reg + 1'b1;
        want_ext = ENTRY_W'(want_reg);
        // Free ring slots are written in order from slot zero, so slots at or past the
        // fill mark have never been written and are read as the slot number itself.
        free_entry = free_hit_reg ? free_q : ENTRY_W'(free_raddr_reg);
    end

    always_comb
    begin
        free_we    = cmd.put_hit || cmd.zap_move;
        free_wdata = cmd.put_hit ? want_ext : used_q;
        used_we    = cmd.get_commit || cmd.scan_step;
        used_wdata = cmd.get_commit ? free_entry : used_q;
        // On a scan step or zap move the next entry is fetched ahead; on a match the current head is read.
        used_raddr = (cmd.scan_step || cmd.zap_move) ? used_head_inc : used_head_reg;
    end

    fbpa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_tail),
        .wdata (free_wdata),
        .raddr (free_head_reg),
        .rdata (free_q)
    );

    fbpa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_used_ram (
        .clk   (clk),
        .we    (used_we),
        .waddr (used_tail),
        .wdata (used_wdata),
        .raddr (used_raddr),
        .rdata (used_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= '0;
            free_cnt_reg  <= CAP_CNT;
            free_fill_reg <= '0;
            used_head_reg <= '0;
            used_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.get_commit)
            begin
                free_head_reg <= free_head_inc;
                free_cnt_reg  <= free_cnt_reg - 1'b1;
                used_cnt_reg  <= used_cnt_reg + 1'b1;
            end
            if (cmd.scan_step)
            begin
                used_head_reg <= used_head_inc;
            end
            if (cmd.put_hit || cmd.zap_move)
            begin
                used_head_reg <= used_head_inc;
                used_cnt_reg  <= used_cnt_reg - 1'b1;
                free_cnt_reg  <= free_cnt_reg + 1'b1;
                if (free_fill_reg != CAP_CNT)
                begin
                    free_fill_reg <= free_fill_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg       <= in_op;
            want_reg     <= in_buffer_index;
            status_reg   <= STATUS_OK;
            granted_reg  <= '0;
            returned_reg <= '0;
        end
        if (cmd.free_rd)
        begin
            free_raddr_reg <= free_head_reg;
            free_hit_reg   <= CNT_W'(free_head_reg) < free_fill_reg;
        end
        if (cmd.get_commit)
        begin
            granted_reg <= 8'(free_entry);
        end
        if (cmd.set_empty)
        begin
            status_reg <= STATUS_EMPTY;
        end
        if (cmd.set_not_alloc)
        begin
            status_reg <= STATUS_NOT_ALLOC;
        end
        if (cmd.used_rd)
        begin
            remain_reg <= used_cnt_reg;
        end
        if (cmd.scan_step)
        begin
            remain_reg <= remain_reg - 1'b1;
        end
        if (cmd.zap_move)
        begin
            returned_reg <= returned_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            out_status_reg   <= status_reg;
            out_granted_reg  <= granted_reg;
            out_free_reg     <= 9'(free_cnt_reg);
            out_returned_reg <= returned_reg;
        end
    end

    always_comb
    begin
        sts.op         = op_reg;
        sts.free_empty = (free_cnt_reg == '0);
        sts.used_empty = (used_cnt_reg == '0);
        sts.match      = (used_q == want_ext);
        sts.scan_last  = (remain_reg == CNT_W'(1));
        sts.used_last  = (used_cnt_reg == CNT_W'(1));
    end

    assign out_status         = out_status_reg;
    assign out_granted_index  = out_granted_reg;
    assign out_free_count     = out_free_reg;
    assign out_returned_count = out_returned_reg;

endmodule
`default_nettype wire

[rtl/core/fixed_buffer_pool_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed buffer pool allocator
// Hands out and takes back buffer indices from a pool of CAPACITY buffers.
//
// The req channel takes one word per operation: get, put (with buffer_index)
// or zap; op code 3 is a no-op. The rsp channel returns exactly one word per
// request with status, granted index, free count and zap return count.
// Requests are taken one at a time. A put examines in-use entries up to
// the in-use count, and a zap walks every in-use entry. The walk over the
// in-use ring reads one RAM entry per cycle.
// A new request is accepted in the cycle after the previous response is
// loaded, even while that response still waits on a stalled receiver; a
// further response waits in its final state until the output register
// frees up.
// Reset fills the free ring with indices 0 to CAPACITY-1 and empties the
// in-use ring at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fixed_buffer_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    fbpa_req_if.sink    req,
    fbpa_rsp_if.source  rsp
);

    cmd_t cmd;
    sts_t sts;

    fbpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    fbpa_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .in_op              (req.op),
        .in_buffer_index    (req.buffer_index),
        .out_status         (rsp.status),
        .out_granted_index  (rsp.granted_index),
        .out_free_count     (rsp.free_count),
        .out_returned_count (rsp.returned_count)
    );

endmodule
`default_nettype wire
